// ----- design/rrr_pkg.sv -----
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared constants and codes for the reflect/refract pipeline.
// ----------------------------------------------------------------------------
package rrr_pkg;

  typedef enum logic {
    OP_REFLECT = 1'b0,
    OP_REFRACT = 1'b1
  } op_e;

  // Q8.24 fixed point
  localparam int          Q_FRAC = 24;
  localparam int unsigned ONE_Q  = 32'd1 << Q_FRAC;

  // Latency of one rounded multiply (partial products, then sum and round)
  localparam int MUL_LAT = 2;

  // Square root: radicand magnitude width and root width
  localparam int RAD_W      = 58;
  localparam int ROOT_W     = 41;
  localparam int SQRT_STEPS = 6;
  localparam int SQRT_LAT   = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;

endpackage

// ----- design/rrr_mul.sv -----
// ----------------------------------------------------------------------------
// rrr_mul
// Two-stage signed Q.24 multiply, rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module rrr_mul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int WR = 40
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  output logic signed [WR-1:0] p_o
);

  logic [WA-1:0]  ua;
  logic [WB-1:0]  ub;
  logic [63:0]    ma, mb;
  logic [63:0]    pp_d [4];
  logic [63:0]    pp_q [4];
  logic           neg_q;
  logic [127:0]   sum;
  logic [127:0]   rnd;
  logic [WR-2:0]  mag;
  logic signed [WR-1:0] p_d, p_q;

  assign ua = a_i[WA-1] ? $unsigned(-a_i) : $unsigned(a_i);
  assign ub = b_i[WB-1] ? $unsigned(-b_i) : $unsigned(b_i);
  assign ma = 64'(ua);
  assign mb = 64'(ub);

  // 32x32 partial products
  always_comb begin
    pp_d[0] = 64'(ma[31:0])  * 64'(mb[31:0]);
    pp_d[1] = 64'(ma[31:0])  * 64'(mb[63:32]);
    pp_d[2] = 64'(ma[63:32]) * 64'(mb[31:0]);
    pp_d[3] = 64'(ma[63:32]) * 64'(mb[63:32]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q  <= pp_d;
      neg_q <= a_i[WA-1] ^ b_i[WB-1];
    end
  end

  always_comb begin
    sum = 128'(pp_q[0]) + (128'(pp_q[1]) << 32) + (128'(pp_q[2]) << 32)
        + (128'(pp_q[3]) << 64) + (128'd1 << (rrr_pkg::Q_FRAC - 1));
    rnd = sum >> rrr_pkg::Q_FRAC;
    mag = rnd[WR-2:0];
    p_d = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- design/rrr_sqrt.sv -----
// ----------------------------------------------------------------------------
// rrr_sqrt
// Pipelined restoring square root: floor(sqrt(rad * 2^24)), up to SQRT_STEPS
// root bits per stage.
// ----------------------------------------------------------------------------
module rrr_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [rrr_pkg::RAD_W-1:0]    rad_i,
  output logic [rrr_pkg::ROOT_W-1:0]   root_o
);

  localparam int N    = rrr_pkg::ROOT_W;
  localparam int XW   = rrr_pkg::RAD_W + rrr_pkg::Q_FRAC;
  localparam int RW   = N + 3;
  localparam int SPS  = rrr_pkg::SQRT_STEPS;
  localparam int NSTG = rrr_pkg::SQRT_LAT;

  logic [XW-1:0] x_q    [NSTG];
  logic [RW-1:0] rem_q  [NSTG];
  logic [N-1:0]  root_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [XW-1:0] x_in, x_d;
    logic [RW-1:0] rem_in, rem_d;
    logic [N-1:0]  root_in, root_d;

    if (s == 0) begin : g_first
      assign x_in    = {rad_i, {rrr_pkg::Q_FRAC{1'b0}}};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    always_comb begin
      x_d    = x_in;
      rem_d  = rem_in;
      root_d = root_in;
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < N) begin
          rem_d = {rem_d[RW-3:0], x_d[XW-1 -: 2]};
          x_d   = {x_d[XW-3:0], 2'b00};
          if (rem_d >= {1'b0, root_d, 2'b01}) begin
            rem_d  = rem_d - {1'b0, root_d, 2'b01};
            root_d = {root_d[N-2:0], 1'b1};
          end else begin
            root_d = {root_d[N-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= root_d;
        if (s < NSTG - 1) begin
          x_q[s]   <= x_d;
          rem_q[s] <= rem_d;
        end
      end
    end
  end

  assign root_o = root_q[NSTG-1];

endmodule

// ----- design/ray_reflect_refract.sv -----
// Throughput: one transfer per cycle while the output is not stalled; set by the
// fully pipelined multipliers and the staged square root, every stage registered.
// A stall at the output holds the whole pipeline in place.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// ray_reflect_refract
// Mirror reflection and Snell refraction of a Q8.24 direction vector.
// ----------------------------------------------------------------------------
module ray_reflect_refract (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [31:0] incident_x_i,
  input  logic signed [31:0] incident_y_i,
  input  logic signed [31:0] incident_z_i,
  input  logic signed [31:0] normal_x_i,
  input  logic signed [31:0] normal_y_i,
  input  logic signed [31:0] normal_z_i,
  input  logic        [31:0] index_ratio_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               saturated_o
);

  localparam int ML = rrr_pkg::MUL_LAT;

  // stage timing
  localparam int T_IN   = 1;
  localparam int T_DOT  = T_IN + ML;
  localparam int T_K    = T_DOT + 1;
  localparam int T_Q    = T_K + ML;
  localparam int T_U    = T_Q + 1;
  localparam int T_V    = T_U + ML;
  localparam int T_P    = T_V + 1;
  localparam int T_SQ   = T_P + ML;
  localparam int T_RAD  = T_SQ + 1;
  localparam int T_ROOT = T_RAD + rrr_pkg::SQRT_LAT;
  localparam int T_Q2   = T_ROOT + ML;
  localparam int T_OUT  = T_Q2 + 1;

  // datapath widths
  localparam int DOT_W = 40;
  localparam int D_W   = 42;
  localparam int K_W   = 43;
  localparam int Q_W   = 51;
  localparam int U_W   = 52;
  localparam int V_W   = 61;
  localparam int P_W   = 52;
  localparam int PS_W  = 42;
  localparam int SQ_W  = 58;
  localparam int NSQ_W = 60;
  localparam int DF_W  = 61;
  localparam int Q2_W  = 50;
  localparam int R_W   = 53;

  localparam logic signed [D_W-1:0] ONE_D = D_W'(rrr_pkg::ONE_Q);
  localparam logic signed [V_W-1:0] P_MAX = V_W'(64'd1 << 40);
  localparam logic signed [R_W-1:0] O_MAX = R_W'(32'sh7fff_ffff);
  localparam logic signed [R_W-1:0] O_MIN = R_W'($signed(32'h8000_0000));

  typedef struct packed {
    logic             op;
    logic [2:0][31:0] a;
    logic [2:0][31:0] n;
    logic [31:0]      ratio;
  } side_t;

  logic                 en;
  logic [T_OUT:T_IN]    vld_q;
  side_t                in_side;
  side_t                side_q [T_IN:T_ROOT];

  logic signed [DOT_W-1:0] dot [3];
  logic signed [D_W-1:0]   d, negd, c;
  logic signed [K_W-1:0]   k_d, k_q;
  logic signed [Q_W-1:0]   q [3];
  logic signed [U_W-1:0]   u_d [3];
  logic signed [U_W-1:0]   u_q [3];
  logic signed [32:0]      rmul;
  logic signed [V_W-1:0]   v [3];
  logic signed [P_W-1:0]   p_d [3];
  logic                    psat_d;
  logic signed [P_W-1:0]   p_q [T_P:T_Q2][3];
  logic                    sat_q [T_P:T_Q2];
  logic signed [SQ_W-1:0]  sq [3];
  logic [NSQ_W-1:0]        nsq;
  logic signed [DF_W-1:0]  diff;
  logic [rrr_pkg::RAD_W-1:0]  rad_d, rad_q;
  logic [rrr_pkg::ROOT_W-1:0] root;
  logic signed [rrr_pkg::ROOT_W:0] smul;
  logic signed [Q2_W-1:0]  q2 [3];
  logic signed [R_W-1:0]   r [3];
  logic signed [31:0]      o_d [3];
  logic signed [31:0]      o_q [3];
  logic                    osat_d, osat_q;

  // global advance: the output register is empty or being drained
  assign en         = !vld_q[T_OUT] || out_ready_i;
  assign in_ready_o = en;

  assign in_side.op    = operation_i;
  assign in_side.a     = {incident_z_i, incident_y_i, incident_x_i};
  assign in_side.n     = {normal_z_i, normal_y_i, normal_x_i};
  assign in_side.ratio = index_ratio_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[T_OUT-1:T_IN], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[T_IN] <= in_side;
      for (int t = T_IN + 1; t <= T_ROOT; t++) begin
        side_q[t] <= side_q[t-1];
      end
    end
  end

  // a.n
  for (genvar i = 0; i < 3; i++) begin : g_dot
    rrr_mul #(.WA(32), .WB(32), .WR(DOT_W)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(side_q[T_IN].a[i])),
      .b_i   ($signed(side_q[T_IN].n[i])),
      .p_o   (dot[i])
    );
  end

  // reflect scales n by 2(a.n), refract by min(-(a.n), 1)
  always_comb begin
    d    = D_W'(dot[0]) + D_W'(dot[1]) + D_W'(dot[2]);
    negd = -d;
    c    = (negd > ONE_D) ? ONE_D : negd;
    k_d  = (side_q[T_DOT].op == rrr_pkg::OP_REFRACT) ? K_W'(c) : K_W'(d) + K_W'(d);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_q <= k_d;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_kn
    rrr_mul #(.WA(K_W), .WB(32), .WR(Q_W)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (k_q),
      .b_i   ($signed(side_q[T_K].n[i])),
      .p_o   (q[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_q[T_Q].op == rrr_pkg::OP_REFRACT) begin
        u_d[i] = U_W'($signed(side_q[T_Q].a[i])) + U_W'(q[i]);
      end else begin
        u_d[i] = U_W'($signed(side_q[T_Q].a[i])) - U_W'(q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= u_d;
    end
  end

  // reflect passes u through a multiply by 1.0, which is exact
  assign rmul = (side_q[T_U].op == rrr_pkg::OP_REFRACT)
              ? $signed({1'b0, side_q[T_U].ratio})
              : $signed({1'b0, 32'(rrr_pkg::ONE_Q)});

  for (genvar i = 0; i < 3; i++) begin : g_ratio
    rrr_mul #(.WA(33), .WB(U_W), .WR(V_W)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (rmul),
      .b_i   (u_q[i]),
      .p_o   (v[i])
    );
  end

  // perpendicular part clipped to +-65536.0 in refract
  always_comb begin
    psat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p_d[i] = P_W'(v[i]);
      if (side_q[T_V].op == rrr_pkg::OP_REFRACT) begin
        if (v[i] > P_MAX) begin
          p_d[i] = P_W'(P_MAX);
          psat_d = 1'b1;
        end else if (v[i] < -P_MAX) begin
          p_d[i] = P_W'(-P_MAX);
          psat_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[T_P]   <= p_d;
      sat_q[T_P] <= psat_d;
      for (int t = T_P + 1; t <= T_Q2; t++) begin
        p_q[t]   <= p_q[t-1];
        sat_q[t] <= sat_q[t-1];
      end
    end
  end

  // |perp|^2
  for (genvar i = 0; i < 3; i++) begin : g_sq
    rrr_mul #(.WA(PS_W), .WB(PS_W), .WR(SQ_W)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ($signed(p_q[T_P][i][PS_W-1:0])),
      .b_i   ($signed(p_q[T_P][i][PS_W-1:0])),
      .p_o   (sq[i])
    );
  end

  always_comb begin
    nsq   = NSQ_W'(sq[0][SQ_W-2:0]) + NSQ_W'(sq[1][SQ_W-2:0])
          + NSQ_W'(sq[2][SQ_W-2:0]);
    diff  = $signed(DF_W'(rrr_pkg::ONE_Q)) - $signed({1'b0, nsq});
    rad_d = diff[DF_W-1] ? rrr_pkg::RAD_W'(-diff) : rrr_pkg::RAD_W'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= rad_d;
    end
  end

  rrr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // reflect subtracts nothing here
  assign smul = (side_q[T_ROOT].op == rrr_pkg::OP_REFRACT) ? $signed({1'b0, root}) : '0;

  for (genvar i = 0; i < 3; i++) begin : g_sn
    rrr_mul #(.WA(rrr_pkg::ROOT_W + 1), .WB(32), .WR(Q2_W)) u_mul (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (smul),
      .b_i   ($signed(side_q[T_ROOT].n[i])),
      .p_o   (q2[i])
    );
  end

  always_comb begin
    osat_d = sat_q[T_Q2];
    for (int i = 0; i < 3; i++) begin
      r[i] = R_W'(p_q[T_Q2][i]) - R_W'(q2[i]);
      if (r[i] > O_MAX) begin
        o_d[i] = 32'(O_MAX);
        osat_d = 1'b1;
      end else if (r[i] < O_MIN) begin
        o_d[i] = 32'(O_MIN);
        osat_d = 1'b1;
      end else begin
        o_d[i] = 32'(r[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_q    <= o_d;
      osat_q <= osat_d;
    end
  end

  assign out_valid_o = vld_q[T_OUT];
  assign out_x_o     = o_q[0];
  assign out_y_o     = o_q[1];
  assign out_z_o     = o_q[2];
  assign saturated_o = osat_q;

endmodule
